// ===== rtl/dequ_pkg.sv =====
// ----------------------------------------------------------------------------
// dequ_pkg
// Shared types and constants for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dequ_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ITEM_BITS_DEF = 32;
    localparam int ACTION_W      = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_R = 3'd0,
        ACT_POP_L  = 3'd1,
        ACT_POP_R  = 3'd2,
        ACT_PEEK_L = 3'd3,
        ACT_PEEK_R = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cell control: take the push value, take the right neighbor's
    // value, or drive the stored value onto the read bus.
    typedef struct packed {
        logic load;
        logic shift;
        logic tap;
    } t_cell_ctrl;

endpackage

// ===== rtl/dequ_if.sv =====
// ----------------------------------------------------------------------------
// dequ_req_if / dequ_rsp_if
// Valid/ready channels for the queue requests and their results.
// ----------------------------------------------------------------------------
interface dequ_req_if #(
    parameter int ITEM_BITS = dequ_pkg::ITEM_BITS_DEF
);
    import dequ_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ITEM_BITS-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface dequ_rsp_if #(
    parameter int ITEM_BITS = dequ_pkg::ITEM_BITS_DEF,
    parameter int CNT_W     = 5
);
    import dequ_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ITEM_BITS-1:0] item_value;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     item_count;
    logic                 is_empty;

    modport source (output valid, output item_value, output status,
                    output item_count, output is_empty, input ready);
    modport sink   (input valid, input item_value, input status,
                    input item_count, input is_empty, output ready);
endinterface

// ===== rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue with push on the right and pop or peek at
// either end. Items sit left-aligned in a row of DEPTH cells: cell 0 holds
// the leftmost item, and a left pop moves every item one cell to the left.
// The unit takes one request per clock and returns its result in the next
// cycle from an output register; a new request is taken whenever that
// register is empty or being read in the same cycle. The cycle time is set
// by the right-end read, a one-hot select across all cells. A pop or peek
// on an empty queue returns status empty, a push on a full queue returns
// status full, and neither changes the contents. Action codes 5 to 7 do
// nothing and report the current count. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH     = dequ_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = dequ_pkg::ITEM_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dequ_req_if.sink   i_req,
    dequ_rsp_if.source o_rsp
);
    import dequ_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                 r_out_valid;
    logic [ITEM_BITS-1:0] r_item_value;
    logic [STATUS_W-1:0]  r_status;
    logic [CNT_W-1:0]     r_item_count;
    logic                 r_is_empty;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic                 w_accept;
    logic                 w_push_ok;
    logic                 w_pop_left;
    logic                 w_rd_left;
    logic                 w_rd_right;
    t_status              w_status;
    logic [CNT_W-1:0]     w_last_idx;
    logic [ITEM_BITS-1:0] w_rd_data;

    logic [ITEM_BITS-1:0] w_cell_data [DEPTH];
    logic [ITEM_BITS-1:0] w_cell_tap  [DEPTH];
    t_cell_ctrl           w_ctrl      [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_last_idx  = r_count - 1'b1;

    // Decode the request against the current fill level.
    always_comb begin
        w_push_ok  = 1'b0;
        w_pop_left = 1'b0;
        w_rd_left  = 1'b0;
        w_rd_right = 1'b0;
        w_status   = ST_OK;
        n_count    = r_count;
        case (t_action'(i_req.action))
            ACT_PUSH_R: begin
                if (r_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_push_ok = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            ACT_POP_L, ACT_PEEK_L: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rd_left = 1'b1;
                    if (t_action'(i_req.action) == ACT_POP_L) begin
                        w_pop_left = 1'b1;
                        n_count    = r_count - 1'b1;
                    end
                end
            end
            ACT_POP_R, ACT_PEEK_R: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_rd_right = 1'b1;
                    if (t_action'(i_req.action) == ACT_POP_R) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        always_comb begin
            w_ctrl[i].load  = w_accept && w_push_ok && (r_count == IDX);
            w_ctrl[i].shift = w_accept && w_pop_left;
            w_ctrl[i].tap   = (w_rd_left && (IDX == '0)) ||
                              (w_rd_right && (IDX == w_last_idx));
        end

        if (i < DEPTH - 1) begin : g_mid
            dequ_cell #(.ITEM_BITS(ITEM_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl[i]),
                .i_push_value (i_req.push_value),
                .i_neighbor   (w_cell_data[i+1]),
                .o_data       (w_cell_data[i]),
                .o_tap        (w_cell_tap[i])
            );
        end else begin : g_end
            dequ_cell #(.ITEM_BITS(ITEM_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl[i]),
                .i_push_value (i_req.push_value),
                .i_neighbor   ({ITEM_BITS{1'b0}}),
                .o_data       (w_cell_data[i]),
                .o_tap        (w_cell_tap[i])
            );
        end
    end

    // At most one cell drives its tap, so OR the taps together.
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | w_cell_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item_value <= w_rd_data;
            r_status     <= w_status;
            r_item_count <= n_count;
            r_is_empty   <= (n_count == '0);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.item_value = r_item_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.item_count = r_item_count;
    assign o_rsp.is_empty   = r_is_empty;

endmodule

// ===== rtl/dequ_cell.sv =====
// ----------------------------------------------------------------------------
// dequ_cell
// One storage cell of the queue chain. Holds one item, loads a pushed item,
// takes its right neighbor's item on a left pop, and drives the read bus.
// ----------------------------------------------------------------------------
module dequ_cell #(
    parameter int ITEM_BITS = dequ_pkg::ITEM_BITS_DEF
) (
    input  logic                 i_clk,
    input  dequ_pkg::t_cell_ctrl i_ctrl,
    input  logic [ITEM_BITS-1:0] i_push_value,
    input  logic [ITEM_BITS-1:0] i_neighbor,
    output logic [ITEM_BITS-1:0] o_data,
    output logic [ITEM_BITS-1:0] o_tap
);
    import dequ_pkg::*;

    logic [ITEM_BITS-1:0] r_data;
    logic [ITEM_BITS-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_push_value;
        end else if (i_ctrl.shift) begin
            n_data = i_neighbor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = i_ctrl.tap ? r_data : '0;

endmodule

// ===== rtl/dequ_chk.sv =====
// ----------------------------------------------------------------------------
// dequ_chk
// Port-level checks for the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module dequ_chk #(
    parameter int DEPTH     = dequ_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = dequ_pkg::ITEM_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [ITEM_BITS-1:0]          i_item_value,
    input logic [dequ_pkg::STATUS_W-1:0] i_status,
    input logic [CNT_W-1:0]              i_item_count,
    input logic                          i_is_empty
);
    import dequ_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // No result shows in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

    // Hold a stalled result.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_item_value) && $stable(i_status) &&
             $stable(i_item_count) && $stable(i_is_empty)))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_empty == (i_item_count == '0)) &&
                        (i_item_count <= FULL_CNT))
        else $error("count and empty flag disagree");

    a_error_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_EMPTY) |->
            (i_item_count == '0 && i_item_value == '0))
        else $error("empty status with items held or data returned");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == ST_FULL) |->
            (i_item_count == FULL_CNT && i_item_value == '0))
        else $error("full status on a queue that is not full");

endmodule

bind double_ended_queue_unit dequ_chk #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS),
    .CNT_W     (CNT_W)
) u_dequ_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_item_value (o_rsp.item_value),
    .i_status     (o_rsp.status),
    .i_item_count (o_rsp.item_count),
    .i_is_empty   (o_rsp.is_empty)
);
